// ===== rtl/core/fss_pkg.sv =====
// ----------------------------------------------------------------------------
// fss_pkg
// Shared types, constants and helper functions of the fuzzy subsequence
// scorer: item kinds, register indexes, the command word that travels from
// the front to the back, and the weight clamps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

    // Query store geometry
    localparam int QUERY_DEPTH = 32;
    localparam int QIDX_W      = (QUERY_DEPTH > 1) ? $clog2(QUERY_DEPTH) : 1;
    localparam int QLEN_W      = $clog2(QUERY_DEPTH + 1);

    // Weights and score widths
    localparam int MAX_WEIGHT = 1024;
    localparam int WEIGHT_W   = 12;
    localparam int CAP_W      = 11;
    localparam int SCORE_W    = 19;
    localparam int SUM_W      = 21;
    localparam int SEEN_W     = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
    localparam logic signed [SUM_W-1:0] SCORE_MAX = SUM_W'(262143);
    localparam logic signed [SUM_W-1:0] SCORE_MIN = -SUM_W'(262144);

    // Command queue
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    // Characters used in classification
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_CAND   = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE     = 3'd0,
        CFG_BOUNDARY = 3'd1,
        CFG_CONTIG   = 3'd2,
        CFG_EXACT    = 3'd3,
        CFG_CAP      = 3'd4
    } t_cfg_idx;

    // Classified item as queued between front and back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] raw;
        logic [7:0] folded;
        logic       is_sep;
        logic       last;
    } t_cmd;

    // Clamped weight set
    typedef struct packed {
        logic signed [WEIGHT_W-1:0] base;
        logic signed [WEIGHT_W-1:0] boundary;
        logic signed [WEIGHT_W-1:0] contig;
        logic signed [WEIGHT_W-1:0] exact;
        logic [CAP_W-1:0]           cap;
    } t_weights;

    // ASCII lower-case fold
    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CH_UC_A && b <= CH_UC_Z) begin
            r = b - CH_UC_A + CH_LC_A;
        end
        return r;
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        return (b == CH_SLASH) || (b == CH_UNDER) || (b == CH_DASH) || (b == CH_DOT);
    endfunction

    // Clamp a 12 bit signed weight to +/- MAX_WEIGHT
    function automatic logic signed [WEIGHT_W-1:0] clamp_weight(
        input logic [WEIGHT_W-1:0] raw
    );
        logic signed [WEIGHT_W-1:0] v;
        v = signed'(raw);
        if (v > WEIGHT_W'(MAX_WEIGHT)) begin
            v = WEIGHT_W'(MAX_WEIGHT);
        end else if (v < -WEIGHT_W'(MAX_WEIGHT)) begin
            v = -WEIGHT_W'(MAX_WEIGHT);
        end
        return v;
    endfunction

    function automatic logic [CAP_W-1:0] clamp_cap(input logic [CAP_W-1:0] raw);
        logic [CAP_W-1:0] v;
        v = raw;
        if (raw > CAP_W'(MAX_WEIGHT)) begin
            v = CAP_W'(MAX_WEIGHT);
        end
        return v;
    endfunction

    // Saturate a wide sum to the 19 bit score range
    function automatic logic signed [SCORE_W-1:0] sat_score(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SCORE_W-1:0] r;
        if (v > SCORE_MAX) begin
            r = SCORE_W'(SCORE_MAX);
        end else if (v < SCORE_MIN) begin
            r = SCORE_W'(SCORE_MIN);
        end else begin
            r = SCORE_W'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fuzzy_subsequence_scorer.sv =====
// ----------------------------------------------------------------------------
// fuzzy_subsequence_scorer
// Case-folded greedy subsequence scorer with boundary, contiguity and
// exact-case bonuses and a capped length penalty.
// ----------------------------------------------------------------------------
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_kind, i_data_byte, i_last
//   out      output     o_out_valid / i_out_ready  o_matched, o_score
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One item per cycle sustained unless a result stall fills the queue; the back
// end scores a candidate byte from the query store read at the match position.
// An item passes through the command queue and then the result register.
// Reset is synchronous, active low; the query store is not cleared.
// The 4-entry command queue absorbs output stalls; the input stalls when full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fuzzy_subsequence_scorer import fss_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_kind,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_matched,
    output logic signed [SCORE_W-1:0]  o_score,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_weights r_weights;
    logic     q_full;
    logic     q_valid;
    logic     push;
    logic     pop;
    t_cmd     front_cmd;
    t_cmd     back_cmd;

    // Configuration registers, clamped on write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weights <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE:     r_weights.base     <= clamp_weight(i_cfg_data);
                CFG_BOUNDARY: r_weights.boundary <= clamp_weight(i_cfg_data);
                CFG_CONTIG:   r_weights.contig   <= clamp_weight(i_cfg_data);
                CFG_EXACT:    r_weights.exact    <= clamp_weight(i_cfg_data);
                CFG_CAP:      r_weights.cap      <= clamp_cap(i_cfg_data[CAP_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // Front end
    fss_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    // Command queue
    fss_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_cmd   (back_cmd)
    );

    // Back end
    fss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_weights   (r_weights),
        .i_q_valid   (q_valid),
        .i_cmd       (back_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_matched   (o_matched),
        .o_score     (o_score)
    );

endmodule

`default_nettype wire

// ===== rtl/core/fss_front.sv =====
// ----------------------------------------------------------------------------
// fss_front
// Front end: classifies each incoming item (folded byte, separator flag)
// and pushes it into the command queue when there is room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_front import fss_pkg::*; (
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_kind,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_cmd            o_cmd
);

    // Handshake: take a transfer whenever the queue has a free slot
    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Classification
    always_comb begin
        o_cmd.kind   = t_kind'(i_kind);
        o_cmd.raw    = i_data_byte;
        o_cmd.folded = fold_byte(i_data_byte);
        o_cmd.is_sep = is_separator(i_data_byte);
        o_cmd.last   = i_last && (t_kind'(i_kind) == KIND_CAND);
    end

endmodule

`default_nettype wire

// ===== rtl/core/fss_fifo.sv =====
// ----------------------------------------------------------------------------
// fss_fifo
// Short command queue between front and back so that each side can stall
// on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fss_fifo import fss_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd                r_mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] r_wr_ptr;
    logic [CQ_PTR_W-1:0] r_rd_ptr;
    logic [CQ_CNT_W-1:0] r_count;

    assign o_full  = (r_count == CQ_CNT_W'(CQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/fss_back.sv =====
// ----------------------------------------------------------------------------
// fss_back
// Back end: holds the query store and the per-candidate match state,
// scores one candidate byte per cycle unless a held result stalls it, and
// drives the result register.
`timescale 1ns / 1ps
`default_nettype none

module fss_back import fss_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_weights i_weights,
    input  wire logic     i_q_valid,
    input  wire t_cmd     i_cmd,
    output logic          o_pop,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output logic          o_matched,
    output logic signed [SCORE_W-1:0] o_score
);

    // Query store and candidate state
    logic [7:0]                r_qstore [QUERY_DEPTH];
    logic [QLEN_W-1:0]         r_qlen;
    logic [QLEN_W-1:0]         r_mpos;
    logic signed [SCORE_W-1:0] r_score;
    logic [SEEN_W-1:0]         r_seen;
    logic                      r_prev_sep;
    logic                      r_prev_hit;
    logic                      r_at_start;

    // Result register
    logic                      r_out_valid;
    logic                      r_matched;
    logic signed [SCORE_W-1:0] r_out_score;

    logic                      needs_out;
    logic [7:0]                want;
    logic                      hit;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SCORE_W-1:0] score_next;
    logic [QLEN_W-1:0]         mpos_next;
    logic [SEEN_W-1:0]         seen_next;
    logic [CAP_W-1:0]          pen;
    logic signed [SUM_W-1:0]   pen_s;
    logic                      res_matched;
    logic signed [SCORE_W-1:0] res_score;

    // Results come from empty candidates and final candidate bytes
    assign needs_out = (i_cmd.kind == KIND_EMPTY) || (i_cmd.kind == KIND_CAND && i_cmd.last);
    assign o_pop     = i_q_valid && (!needs_out || !r_out_valid || i_out_ready);

    // Candidate byte scoring
    always_comb begin
        want = r_qstore[r_mpos[QIDX_W-1:0]];
        hit  = (r_mpos < r_qlen) && (fold_byte(want) == i_cmd.folded);
        sum  = SUM_W'(r_score) + SUM_W'(i_weights.base);
        if (r_at_start || r_prev_sep) begin
            sum = sum + SUM_W'(i_weights.boundary);
        end
        if (r_prev_hit) begin
            sum = sum + SUM_W'(i_weights.contig);
        end
        if (i_cmd.raw == want) begin
            sum = sum + SUM_W'(i_weights.exact);
        end
        score_next = hit ? sat_score(sum) : r_score;
        mpos_next  = hit ? r_mpos + 1'b1 : r_mpos;
        seen_next  = (r_seen == SEEN_MAX) ? r_seen : r_seen + 1'b1;
        pen        = (seen_next < i_weights.cap) ? seen_next : i_weights.cap;
        pen_s      = SUM_W'(pen);
    end

    // Result of the item at the head of the queue
    always_comb begin
        res_matched = 1'b0;
        res_score   = '0;
        if (i_cmd.kind == KIND_EMPTY) begin
            res_matched = (r_qlen == '0);
        end else if (r_qlen == '0) begin
            res_matched = 1'b1;
        end else if (mpos_next >= r_qlen) begin
            res_matched = 1'b1;
            res_score   = sat_score(SUM_W'(score_next) - pen_s);
        end
    end

    // Query store writes
    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.kind == KIND_APPEND && r_qlen < QLEN_W'(QUERY_DEPTH)) begin
            r_qstore[r_qlen[QIDX_W-1:0]] <= i_cmd.raw;
        end
    end

    // Query length and candidate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen     <= '0;
            r_mpos     <= '0;
            r_score    <= '0;
            r_seen     <= '0;
            r_prev_sep <= 1'b0;
            r_prev_hit <= 1'b0;
            r_at_start <= 1'b1;
        end else if (o_pop) begin
            if (i_cmd.kind == KIND_CAND && !i_cmd.last) begin
                r_mpos     <= mpos_next;
                r_score    <= score_next;
                r_seen     <= seen_next;
                r_prev_sep <= i_cmd.is_sep;
                r_prev_hit <= hit;
                r_at_start <= 1'b0;
            end else begin
                r_mpos     <= '0;
                r_score    <= '0;
                r_seen     <= '0;
                r_prev_sep <= 1'b0;
                r_prev_hit <= 1'b0;
                r_at_start <= 1'b1;
            end
            case (i_cmd.kind)
                KIND_CLEAR: begin
                    r_qlen <= '0;
                end
                KIND_APPEND: begin
                    if (r_qlen < QLEN_W'(QUERY_DEPTH)) begin
                        r_qlen <= r_qlen + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: accepts a new result while the old one is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && needs_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && needs_out) begin
            r_matched   <= res_matched;
            r_out_score <= res_score;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;
    assign o_score     = r_out_score;

endmodule

`default_nettype wire

// ===== tb/sv/fss_score_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_score_checker
// Watches the config, item and result channels of the fuzzy subsequence
// scorer. Keeps its own copy of the weights, the query and the candidate in
// progress, works out the score of every finished candidate, and compares
// each result transfer with the oldest score still due.
// ----------------------------------------------------------------------------
module fss_score_checker import fss_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    input  wire logic [1:0]                i_kind,
    input  wire logic [7:0]                i_data_byte,
    input  wire logic                      i_last,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic                      i_matched,
    input  wire logic signed [SCORE_W-1:0] i_score,
    input  wire logic                      i_cfg_valid,
    input  wire logic                      i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     i_cfg_data,
    output int                             o_errors,
    output int                             o_pending
);

    localparam int SCORE_HI   = 262143;
    localparam int SCORE_LO   = -262144;
    localparam int SEEN_LIMIT = 2047;

    typedef struct packed {
        logic                      matched;
        logic signed [SCORE_W-1:0] score;
    } t_verdict;

    // scores still owed by the block, oldest first
    t_verdict scores_due[$];

    // weight register copies, raw as written
    logic [WEIGHT_W-1:0] reg_base;
    logic [WEIGHT_W-1:0] reg_boundary;
    logic [WEIGHT_W-1:0] reg_contig;
    logic [WEIGHT_W-1:0] reg_exact;
    logic [CAP_W-1:0]    reg_cap;

    // query and candidate tracking
    logic [7:0] query_bytes [QUERY_DEPTH];
    int         query_len;
    int         next_pos;
    int         partial_score;
    int         bytes_seen;
    logic [7:0] prior_byte;
    bit         prior_hit;
    bit         fresh;
    int         err_count = 0;

    function automatic logic [7:0] lower_ascii(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h5A) begin
            return b + 8'h20;
        end
        return b;
    endfunction

    function automatic bit is_punct(input logic [7:0] b);
        return b == CH_SLASH || b == CH_UNDER || b == CH_DASH || b == CH_DOT;
    endfunction

    // signed 12 bit register value, clamped to +/- MAX_WEIGHT
    function automatic int weight_of(input logic [WEIGHT_W-1:0] raw);
        int v;
        v = int'(signed'(raw));
        if (v > MAX_WEIGHT) begin
            v = MAX_WEIGHT;
        end else if (v < -MAX_WEIGHT) begin
            v = -MAX_WEIGHT;
        end
        return v;
    endfunction

    function automatic int clip_score(input int v);
        if (v > SCORE_HI) begin
            return SCORE_HI;
        end
        if (v < SCORE_LO) begin
            return SCORE_LO;
        end
        return v;
    endfunction

    task automatic restart_candidate();
        next_pos      = 0;
        partial_score = 0;
        bytes_seen    = 0;
        prior_byte    = 8'h00;
        prior_hit     = 1'b0;
        fresh         = 1'b1;
    endtask

    always @(posedge i_clk) begin : watch
        t_verdict   due;
        t_verdict   got;
        logic [7:0] want;
        logic [7:0] b;
        int         s;
        int         cap;
        int         penalty;
        bit         hit;

        if (!i_rst_n) begin
            reg_base     = '0;
            reg_boundary = '0;
            reg_contig   = '0;
            reg_exact    = '0;
            reg_cap      = '0;
            query_len    = 0;
            for (int i = 0; i < QUERY_DEPTH; i++) begin
                query_bytes[i] = 8'h00;
            end
            restart_candidate();
            scores_due.delete();
        end else begin
            // register write
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BASE:     reg_base     = i_cfg_data;
                    CFG_BOUNDARY: reg_boundary = i_cfg_data;
                    CFG_CONTIG:   reg_contig   = i_cfg_data;
                    CFG_EXACT:    reg_exact    = i_cfg_data;
                    CFG_CAP:      reg_cap      = i_cfg_data[CAP_W-1:0];
                    default: ;
                endcase
            end

            // result transfer against the oldest score due
            if (i_out_valid && i_out_ready) begin
                got.matched = i_matched;
                got.score   = i_score;
                if (scores_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, got matched %0b score %0d",
                             $time, got.matched, got.score);
                end else begin
                    due = scores_due.pop_front();
                    if (got.matched !== due.matched) begin
                        err_count++;
                        $display("%0t: matched: expected %0b, got %0b",
                                 $time, due.matched, got.matched);
                    end
                    if (got.score !== due.score) begin
                        err_count++;
                        $display("%0t: score: expected %0d, got %0d",
                                 $time, due.score, got.score);
                    end
                end
            end

            // item transfer
            if (i_in_valid && i_in_ready) begin
                b = i_data_byte;
                case (t_kind'(i_kind))
                    KIND_CLEAR: begin
                        query_len = 0;
                        restart_candidate();
                    end
                    KIND_APPEND: begin
                        // appends past the store depth are dropped
                        if (query_len < QUERY_DEPTH) begin
                            query_bytes[query_len] = b;
                            query_len++;
                        end
                        restart_candidate();
                    end
                    KIND_EMPTY: begin
                        restart_candidate();
                        due.matched = (query_len == 0);
                        due.score   = '0;
                        scores_due.insert(scores_due.size(), due);
                    end
                    default: begin
                        // greedy match of the next query byte
                        hit = 1'b0;
                        if (next_pos < query_len) begin
                            want = query_bytes[next_pos];
                            if (lower_ascii(b) == lower_ascii(want)) begin
                                hit = 1'b1;
                                s = partial_score + weight_of(reg_base);
                                if (fresh || is_punct(prior_byte)) begin
                                    s += weight_of(reg_boundary);
                                end
                                if (prior_hit) begin
                                    s += weight_of(reg_contig);
                                end
                                if (b == want) begin
                                    s += weight_of(reg_exact);
                                end
                                partial_score = clip_score(s);
                                next_pos++;
                            end
                        end
                        prior_hit  = hit;
                        prior_byte = b;
                        fresh      = 1'b0;
                        if (bytes_seen < SEEN_LIMIT) begin
                            bytes_seen++;
                        end

                        // end of candidate: apply the capped length penalty
                        if (i_last) begin
                            due.score = '0;
                            if (query_len == 0) begin
                                due.matched = 1'b1;
                            end else if (next_pos >= query_len) begin
                                cap = (reg_cap > MAX_WEIGHT) ? MAX_WEIGHT : int'(reg_cap);
                                penalty = (bytes_seen < cap) ? bytes_seen : cap;
                                due.matched = 1'b1;
                                due.score = SCORE_W'(clip_score(partial_score - penalty));
                            end else begin
                                due.matched = 1'b0;
                            end
                            restart_candidate();
                            scores_due.insert(scores_due.size(), due);
                        end
                    end
                endcase
            end
        end

        o_pending <= scores_due.size();
        o_errors  <= err_count;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fuzzy subsequence scorer: weight settings from the clamp
// extremes to random values, a short directed sequence, then random query
// loads and candidates that mostly contain the query, plus noise, cut-off
// candidates and empty candidates. Both channels idle at random; the result
// side is held off once to back the block up. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb;
    import fss_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 10;
    localparam int LONG_HOLD     = 100;
    localparam int BURST_ITEMS   = 40;
    localparam int LONG_RUN_LEN  = 1030;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam logic [7:0] CH_UC_B = 8'h42;
    localparam logic [7:0] CH_LC_B = 8'h62;
    localparam logic [7:0] CH_LC_Q = 8'h71;
    localparam logic [7:0] CH_UC_Q = 8'h51;
    localparam logic [7:0] CH_LC_X = 8'h78;
    localparam logic [7:0] CH_LC_Z = 8'h7A;
    localparam logic [7:0] CH_AT   = 8'h40;
    localparam logic [7:0] CH_LBRK = 8'h5B;

    typedef logic [7:0] t_bytes[$];

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic [1:0]                i_kind      = KIND_CLEAR;
    logic [7:0]                i_data_byte = 8'h00;
    logic                      i_last      = 1'b0;
    logic                      i_out_ready = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_index = CFG_BASE;
    logic [CFG_DATA_W-1:0]     i_cfg_data  = '0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic                      o_matched;
    logic signed [SCORE_W-1:0] o_score;
    logic                      o_cfg_ready;

    int   fail_count;
    int   due_count;
    int   cycle_count = 0;
    int   items_sent  = 0;
    int   hold_calls  = 0;
    logic quiet       = 1'b0;
    bit   steady      = 1'b0;

    // query as the block should hold it, for building matching candidates
    logic [7:0] query_shadow[$];

    fuzzy_subsequence_scorer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_matched   (o_matched),
        .o_score     (o_score),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    fss_score_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_matched   (o_matched),
        .i_score     (o_score),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (fail_count),
        .o_pending   (due_count)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stall bursts, calm windows, one long hold-off on request
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_calls != holds_done) begin
                holds_done++;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else if (!quiet && (cycle_count / 300) % 3 != 0
                         && $urandom_range(0, 6) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // one item transfer, then maybe a gap with valid low
    task automatic send_item(input t_kind kind, input logic [7:0] b, input logic fin);
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        i_last      <= fin;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
        if (kind == KIND_CLEAR) begin
            query_shadow.delete();
        end else if (kind == KIND_APPEND && query_shadow.size() < QUERY_DEPTH) begin
            query_shadow.insert(query_shadow.size(), b);
        end
        if (!quiet && !steady && (items_sent / 150) % 3 != 1
            && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic send_bytes(input t_bytes seq, input bit finish);
        for (int i = 0; i < seq.size(); i++) begin
            send_item(KIND_CAND, seq[i], finish && i == seq.size() - 1);
        end
    endtask

    // wait until every score is in, then let queued query edits retire
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_count != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic program_weights(input logic [CFG_DATA_W-1:0] base,
                                   input logic [CFG_DATA_W-1:0] bnd,
                                   input logic [CFG_DATA_W-1:0] ctg,
                                   input logic [CFG_DATA_W-1:0] ext,
                                   input logic [CFG_DATA_W-1:0] cap);
        write_reg(CFG_BASE, base);
        write_reg(CFG_BOUNDARY, bnd);
        write_reg(CFG_CONTIG, ctg);
        write_reg(CFG_EXACT, ext);
        write_reg(CFG_CAP, cap);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 5))
            0: begin
                case ($urandom_range(0, 3))
                    0: return CH_SLASH;
                    1: return CH_UNDER;
                    2: return CH_DASH;
                    default: return CH_DOT;
                endcase
            end
            1, 2: return CH_LC_A + 8'($urandom_range(0, 25));
            3: return CH_UC_A + 8'($urandom_range(0, 25));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] b);
        if (((b >= CH_UC_A && b <= CH_UC_Z) || (b >= CH_LC_A && b <= CH_LC_Z))
            && $urandom_range(0, 1) == 1) begin
            return b ^ 8'h20;
        end
        return b;
    endfunction

    // candidate holding the current query as a subsequence, with random padding
    function automatic t_bytes matching_bytes();
        t_bytes seq;
        int     pad;
        foreach (query_shadow[i]) begin
            pad = $urandom_range(0, 4);
            if (pad > 2) begin
                pad = 0;
            end
            repeat (pad) seq.insert(seq.size(), filler_byte());
            seq.insert(seq.size(), flip_case(query_shadow[i]));
        end
        repeat ($urandom_range(0, 2)) seq.insert(seq.size(), filler_byte());
        return seq;
    endfunction

    task automatic load_query(input int n);
        if ($urandom_range(0, 3) != 0) begin
            send_item(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        repeat (n) send_item(KIND_APPEND, filler_byte(), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_traffic(input int count);
        int     stop;
        int     pick;
        t_bytes seq;
        stop = items_sent + count;
        while (items_sent < stop) begin
            pick = $urandom_range(0, 99);
            seq.delete();
            if (pick < 12) begin
                // new query, now and then past the store depth
                if ($urandom_range(0, 19) == 0) begin
                    load_query($urandom_range(30, 35));
                end else begin
                    load_query($urandom_range(0, 5));
                end
            end else if (pick < 78) begin
                seq = matching_bytes();
                if (seq.size() == 0) begin
                    send_item(KIND_EMPTY, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                end else begin
                    send_bytes(seq, 1'b1);
                end
            end else if (pick < 86) begin
                repeat ($urandom_range(1, 8)) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
                send_bytes(seq, 1'b1);
            end else if (pick < 91) begin
                send_item(KIND_EMPTY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else if (pick < 97) begin
                // candidate cut off by a query edit or an empty candidate
                seq = matching_bytes();
                if (seq.size() > 1) begin
                    void'(seq.pop_back());
                end
                send_bytes(seq, 1'b0);
                case ($urandom_range(0, 2))
                    0: send_item(KIND_CLEAR, 8'($urandom_range(0, 255)),
                                 1'($urandom_range(0, 1)));
                    1: send_item(KIND_APPEND, filler_byte(), 1'($urandom_range(0, 1)));
                    default: send_item(KIND_EMPTY, 8'($urandom_range(0, 255)), 1'b0);
                endcase
            end else begin
                send_item(t_kind'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial begin : stimulus
        t_bytes long_run;

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);

        write_reg(CFG_SPARE_5, 12'hFFF);
        program_weights(12'd16, 12'd8, 12'd4, 12'd2, 12'd3);

        // directed: empty query answers
        send_item(KIND_EMPTY, 8'h00, 1'b0);
        send_item(KIND_CAND, 8'hFF, 1'b1);
        send_item(KIND_CLEAR, 8'hFF, 1'b1);
        // query "aB." with last set on one append
        send_item(KIND_APPEND, CH_LC_A, 1'b0);
        send_item(KIND_APPEND, CH_UC_B, 1'b1);
        send_item(KIND_APPEND, CH_DOT, 1'b0);
        // folded match after a separator, then contiguous hits
        send_item(KIND_CAND, CH_LC_X, 1'b0);
        send_item(KIND_CAND, CH_SLASH, 1'b0);
        send_item(KIND_CAND, CH_UC_A, 1'b0);
        send_item(KIND_CAND, CH_LC_B, 1'b0);
        send_item(KIND_CAND, CH_DOT, 1'b1);
        // out of order: no match
        send_item(KIND_CAND, CH_LC_B, 1'b0);
        send_item(KIND_CAND, CH_LC_A, 1'b1);
        // empty candidate with a query loaded
        send_item(KIND_EMPTY, 8'hA5, 1'b1);
        // query edit in the middle of a candidate
        send_item(KIND_CAND, CH_LC_A, 1'b0);
        send_item(KIND_APPEND, 8'hFF, 1'b0);
        // bytes next to the fold range must not fold
        send_item(KIND_CAND, CH_LBRK, 1'b0);
        send_item(KIND_CAND, CH_AT, 1'b0);
        send_item(KIND_CAND, CH_LC_A, 1'b0);
        send_item(KIND_CAND, CH_UC_B, 1'b0);
        send_item(KIND_CAND, CH_DOT, 1'b0);
        send_item(KIND_CAND, 8'hFF, 1'b1);
        // zero byte and the top of the letter range
        send_item(KIND_CLEAR, 8'h00, 1'b0);
        send_item(KIND_APPEND, 8'h00, 1'b0);
        send_item(KIND_APPEND, CH_UC_Z, 1'b0);
        send_item(KIND_CAND, 8'h00, 1'b0);
        send_item(KIND_CAND, CH_LC_Z, 1'b1);
        drain();

        // raw weights above the clamp
        write_reg(CFG_SPARE_6, 12'($urandom));
        program_weights(12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF);
        random_traffic(100);

        // hold the result side off while items keep coming
        hold_calls <= hold_calls + 1;
        steady = 1'b1;
        repeat (BURST_ITEMS) begin
            send_item(($urandom_range(0, 1) == 1) ? KIND_EMPTY : KIND_CAND,
                      8'($urandom_range(0, 255)), 1'b1);
        end
        steady = 1'b0;
        drain();

        // candidate longer than the largest length cap
        send_item(KIND_CLEAR, 8'h00, 1'b0);
        send_item(KIND_APPEND, CH_LC_Q, 1'b0);
        long_run.insert(long_run.size(), CH_UC_Q);
        repeat (LONG_RUN_LEN - 1) long_run.insert(long_run.size(), 8'($urandom_range(0, 255)));
        send_bytes(long_run, 1'b1);
        drain();

        // lowest base, boundary and exact weights, top contiguity weight, no length penalty
        program_weights(12'h800, 12'hC00, 12'h400, 12'h801, 12'h000);
        random_traffic(100);
        drain();

        // random raw values, cap with its top bit set at times
        write_reg(CFG_SPARE_7, 12'($urandom));
        program_weights(12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                        12'($urandom));
        random_traffic(100);
        drain();

        // small weights; cap data with bit 11 set beyond the register width
        program_weights(12'($urandom_range(0, 31)), 12'($urandom_range(0, 31)),
                        12'($urandom_range(0, 31)), 12'($urandom_range(0, 31)),
                        12'h800 | 12'($urandom_range(0, 15)));
        random_traffic(90);
        quiet <= 1'b1;
        random_traffic(60);
        drain();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
